FILE: design/qrs_pkg.sv
// shared types and constants of the quadratic root solver
package qrs_pkg;

    // width of the near-zero threshold register
    localparam int EPS_WIDTH = 16;

    // threshold after reset, 0.001 in Q16.16
    localparam logic [EPS_WIDTH-1:0] THRESH_RESET = 16'd66;

    // root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ANY  = 2'd3;

    // solution class carried down the pipeline
    typedef enum logic [4:0] {
        MODE_NONE = 5'b00001,
        MODE_ANY  = 5'b00010,
        MODE_LIN  = 5'b00100,
        MODE_DBL  = 5'b01000,
        MODE_TWO  = 5'b10000
    } t_mode;

endpackage

FILE: design/qrs_if.sv
// handshake interfaces for coefficient items, result items and threshold writes
interface qrs_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          root_count;
    logic signed [W-1:0] root_first;
    logic signed [W-1:0] root_second;
    logic                overflow;

    modport source (output valid, output root_count, output root_first,
                    output root_second, output overflow, input ready);
    modport sink   (input valid, input root_count, input root_first,
                    input root_second, input overflow, output ready);
endinterface

interface qrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/quadratic_root_solver_core.sv
// quadratic root solver core: pipelined discriminant, square root and two dividers
//
// Solves a*x^2+b*x+c=0 on signed fixed-point coefficients (COEF_WIDTH bits,
// FRAC_BITS fraction bits, Q16.16 by default) and accepts one coefficient item
// every clock cycle while the output is not stalled. Each item passes through one
// input stage, one multiply stage, one discriminant stage, COEF_WIDTH+1 square
// root stages (one result bit each), one numerator stage, COEF_WIDTH+FRAC_BITS+2
// divider stages (one quotient bit each, two dividers side by side) and the
// saturating output register. The whole pipeline holds when a finished item is
// not taken; nothing is lost or repeated. The threshold register is written
// through its own channel, which is always ready, and must change only when idle.
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qrs_in_if.sink    i_in,
    qrs_cfg_if.sink   i_cfg,
    qrs_out_if.source o_out
);
    import qrs_pkg::*;

    localparam int W    = COEF_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int DW   = 2 * W + 1;
    localparam int SW   = W + 1;
    localparam int RW   = SW + 2;
    localparam int NUMW = W + 2;
    localparam int DENW = W + 1;
    localparam int NW   = NUMW + F;
    localparam int CW   = DW + EPS_WIDTH + F;
    localparam int RMW  = W + 2;

    logic adv;
    logic [EPS_WIDTH-1:0] r_eps;

    // stage 1: coefficients, magnitudes, near-zero flags
    logic                r1_v;
    logic signed [W-1:0] r1_a, r1_b, r1_c;
    logic [W-1:0]        r1_ma, r1_mb, r1_mc;
    logic                r1_na, r1_nc, r1_za, r1_zb, r1_zc;
    logic [W-1:0]        n1_ma, n1_mb, n1_mc;

    // stage 2: products
    logic                r2_v;
    logic signed [W-1:0] r2_a, r2_b, r2_c;
    logic [PW-1:0]       r2_b2, r2_ac;
    logic                r2_na, r2_nc, r2_za, r2_zb, r2_zc;

    // square root stages
    logic                r_sq_v    [0:SW];
    logic [RW-1:0]       r_sq_rem  [0:SW];
    logic [SW-1:0]       r_sq_root [0:SW];
    logic [2*SW-1:0]     r_sq_d    [0:SW];
    t_mode               r_sq_mode [0:SW];
    logic signed [W-1:0] r_sq_a    [0:SW];
    logic signed [W-1:0] r_sq_b    [0:SW];
    logic signed [W-1:0] r_sq_c    [0:SW];
    logic [RW-1:0]       n_sq_rem  [1:SW];
    logic [SW-1:0]       n_sq_root [1:SW];

    // divider stages
    logic                r_dv_v    [0:NW];
    logic [NW-1:0]       r_dv_q1   [0:NW];
    logic [NW-1:0]       r_dv_q2   [0:NW];
    logic [RMW-1:0]      r_dv_r1   [0:NW];
    logic [RMW-1:0]      r_dv_r2   [0:NW];
    logic [DENW-1:0]     r_dv_den  [0:NW];
    logic                r_dv_neg1 [0:NW];
    logic                r_dv_neg2 [0:NW];
    t_mode               r_dv_mode [0:NW];
    logic [NW-1:0]       n_dv_q1   [1:NW];
    logic [NW-1:0]       n_dv_q2   [1:NW];
    logic [RMW-1:0]      n_dv_r1   [1:NW];
    logic [RMW-1:0]      n_dv_r2   [1:NW];

    // discriminant stage signals
    logic [DW-1:0]  n_dmag;
    logic           n_dneg;
    logic           n_dz;
    t_mode          n_mode;

    // numerator stage signals
    logic signed [NUMW-1:0] n_num1, n_num2;
    logic signed [DENW-1:0] n_den;
    logic [NUMW-1:0]        n_mnum1, n_mnum2;
    logic [DENW-1:0]        n_mden;

    // output stage signals
    logic [NW-1:0] n_res1, n_res2;
    logic          n_ovf1, n_ovf2;

    // output register
    logic                r_out_valid;
    logic [1:0]          r_out_count;
    logic signed [W-1:0] r_out_first, r_out_second;
    logic                r_out_ovf;

    // global advance: move on when the output register is free or being taken
    assign adv         = !r_out_valid || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= THRESH_RESET;
        end else if (i_cfg.valid) begin
            r_eps <= i_cfg.data;
        end
    end

    // input magnitudes
    always_comb begin
        n1_ma = i_in.coef_a[W-1] ? W'(-i_in.coef_a) : W'(i_in.coef_a);
        n1_mb = i_in.coef_b[W-1] ? W'(-i_in.coef_b) : W'(i_in.coef_b);
        n1_mc = i_in.coef_c[W-1] ? W'(-i_in.coef_c) : W'(i_in.coef_c);
    end

    // discriminant magnitude, sign and solution class
    always_comb begin
        logic [DW-1:0] b2;
        logic [DW-1:0] ac4;
        b2  = DW'(r2_b2);
        ac4 = DW'({r2_ac, 2'b00});
        n_dneg = 1'b0;
        if (r2_na != r2_nc) begin
            n_dmag = b2 + ac4;
        end else if (b2 >= ac4) begin
            n_dmag = b2 - ac4;
        end else begin
            n_dmag = ac4 - b2;
            n_dneg = 1'b1;
        end
        n_dz = CW'(n_dmag) < (CW'(r_eps) << F);
        if (r2_za && r2_zb) begin
            n_mode = r2_zc ? MODE_ANY : MODE_NONE;
        end else if (r2_za) begin
            n_mode = MODE_LIN;
        end else if (n_dz) begin
            n_mode = MODE_DBL;
        end else if (n_dneg) begin
            n_mode = MODE_NONE;
        end else begin
            n_mode = MODE_TWO;
        end
    end

    // square root steps, two radicand bits per stage
    always_comb begin
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        for (int k = 0; k < SW; k++) begin
            t     = {r_sq_rem[k], r_sq_d[k][2*SW-1 -: 2]};
            trial = (RW+2)'({r_sq_root[k], 2'b01});
            if (t >= trial) begin
                n_sq_rem[k+1]  = RW'(t - trial);
                n_sq_root[k+1] = {r_sq_root[k][SW-2:0], 1'b1};
            end else begin
                n_sq_rem[k+1]  = RW'(t);
                n_sq_root[k+1] = {r_sq_root[k][SW-2:0], 1'b0};
            end
        end
    end

    // numerators and divisor by solution class
    always_comb begin
        logic signed [NUMW-1:0] nb;
        logic signed [NUMW-1:0] s;
        nb = -NUMW'(r_sq_b[SW]);
        s  = signed'(NUMW'(r_sq_root[SW]));
        n_num2 = '0;
        unique case (r_sq_mode[SW])
            MODE_LIN: begin
                n_num1 = -NUMW'(r_sq_c[SW]);
                n_den  = DENW'(r_sq_b[SW]);
            end
            MODE_DBL: begin
                n_num1 = nb;
                n_den  = signed'({r_sq_a[SW], 1'b0});
            end
            MODE_TWO: begin
                n_num1 = nb + s;
                n_num2 = nb - s;
                n_den  = signed'({r_sq_a[SW], 1'b0});
            end
            default: begin
                n_num1 = '0;
                n_den  = signed'({r_sq_a[SW], 1'b0});
            end
        endcase
        n_mnum1 = n_num1[NUMW-1] ? NUMW'(-n_num1) : NUMW'(n_num1);
        n_mnum2 = n_num2[NUMW-1] ? NUMW'(-n_num2) : NUMW'(n_num2);
        n_mden  = n_den[DENW-1] ? DENW'(-n_den) : DENW'(n_den);
    end

    // restoring division steps, one quotient bit per stage
    always_comb begin
        logic [RMW-1:0] t1;
        logic [RMW-1:0] t2;
        logic [RMW-1:0] d;
        for (int k = 0; k < NW; k++) begin
            d  = RMW'(r_dv_den[k]);
            t1 = {r_dv_r1[k][RMW-2:0], r_dv_q1[k][NW-1]};
            t2 = {r_dv_r2[k][RMW-2:0], r_dv_q2[k][NW-1]};
            if (t1 >= d) begin
                n_dv_r1[k+1] = t1 - d;
                n_dv_q1[k+1] = {r_dv_q1[k][NW-2:0], 1'b1};
            end else begin
                n_dv_r1[k+1] = t1;
                n_dv_q1[k+1] = {r_dv_q1[k][NW-2:0], 1'b0};
            end
            if (t2 >= d) begin
                n_dv_r2[k+1] = t2 - d;
                n_dv_q2[k+1] = {r_dv_q2[k][NW-2:0], 1'b1};
            end else begin
                n_dv_r2[k+1] = t2;
                n_dv_q2[k+1] = {r_dv_q2[k][NW-2:0], 1'b0};
            end
        end
    end

    // saturation and sign of both quotients
    always_comb begin
        logic [NW-1:0] top;
        logic [NW-1:0] lim1;
        logic [NW-1:0] lim2;
        logic [NW-1:0] q1;
        logic [NW-1:0] q2;
        top  = NW'(1) << (W - 1);
        lim1 = r_dv_neg1[NW] ? top : top - NW'(1);
        lim2 = r_dv_neg2[NW] ? top : top - NW'(1);
        n_ovf1 = r_dv_q1[NW] > lim1;
        n_ovf2 = r_dv_q2[NW] > lim2;
        q1 = n_ovf1 ? lim1 : r_dv_q1[NW];
        q2 = n_ovf2 ? lim2 : r_dv_q2[NW];
        n_res1 = r_dv_neg1[NW] ? -q1 : q1;
        n_res2 = r_dv_neg2[NW] ? -q2 : q2;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= SW; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int k = 0; k <= NW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r1_v      <= i_in.valid;
            r2_v      <= r1_v;
            r_sq_v[0] <= r2_v;
            for (int k = 0; k < SW; k++) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_dv_v[0] <= r_sq_v[SW];
            for (int k = 0; k < NW; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_out_valid <= r_dv_v[NW];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // input stage
            r1_a  <= i_in.coef_a;
            r1_b  <= i_in.coef_b;
            r1_c  <= i_in.coef_c;
            r1_ma <= n1_ma;
            r1_mb <= n1_mb;
            r1_mc <= n1_mc;
            r1_na <= i_in.coef_a[W-1];
            r1_nc <= i_in.coef_c[W-1];
            r1_za <= (W+1)'(n1_ma) < (W+1)'(r_eps);
            r1_zb <= (W+1)'(n1_mb) < (W+1)'(r_eps);
            r1_zc <= (W+1)'(n1_mc) < (W+1)'(r_eps);
            // multiply stage
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_b2 <= PW'(r1_mb) * PW'(r1_mb);
            r2_ac <= PW'(r1_ma) * PW'(r1_mc);
            r2_na <= r1_na;
            r2_nc <= r1_nc;
            r2_za <= r1_za;
            r2_zb <= r1_zb;
            r2_zc <= r1_zc;
            // discriminant stage feeds the root
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_d[0]    <= (2*SW)'(n_dmag);
            r_sq_mode[0] <= n_mode;
            r_sq_a[0]    <= r2_a;
            r_sq_b[0]    <= r2_b;
            r_sq_c[0]    <= r2_c;
            for (int k = 0; k < SW; k++) begin
                r_sq_rem[k+1]  <= n_sq_rem[k+1];
                r_sq_root[k+1] <= n_sq_root[k+1];
                r_sq_d[k+1]    <= {r_sq_d[k][2*SW-3:0], 2'b00};
                r_sq_mode[k+1] <= r_sq_mode[k];
                r_sq_a[k+1]    <= r_sq_a[k];
                r_sq_b[k+1]    <= r_sq_b[k];
                r_sq_c[k+1]    <= r_sq_c[k];
            end
            // numerator stage feeds the dividers
            r_dv_q1[0]   <= {n_mnum1, {F{1'b0}}};
            r_dv_q2[0]   <= {n_mnum2, {F{1'b0}}};
            r_dv_r1[0]   <= '0;
            r_dv_r2[0]   <= '0;
            r_dv_den[0]  <= n_mden;
            r_dv_neg1[0] <= n_num1[NUMW-1] != n_den[DENW-1];
            r_dv_neg2[0] <= n_num2[NUMW-1] != n_den[DENW-1];
            r_dv_mode[0] <= r_sq_mode[SW];
            for (int k = 0; k < NW; k++) begin
                r_dv_q1[k+1]   <= n_dv_q1[k+1];
                r_dv_q2[k+1]   <= n_dv_q2[k+1];
                r_dv_r1[k+1]   <= n_dv_r1[k+1];
                r_dv_r2[k+1]   <= n_dv_r2[k+1];
                r_dv_den[k+1]  <= r_dv_den[k];
                r_dv_neg1[k+1] <= r_dv_neg1[k];
                r_dv_neg2[k+1] <= r_dv_neg2[k];
                r_dv_mode[k+1] <= r_dv_mode[k];
            end
            // output register
            unique case (r_dv_mode[NW])
                MODE_ANY: begin
                    r_out_count  <= CNT_ANY;
                    r_out_first  <= '0;
                    r_out_second <= '0;
                    r_out_ovf    <= 1'b0;
                end
                MODE_LIN: begin
                    r_out_count  <= CNT_ONE;
                    r_out_first  <= signed'(n_res1[W-1:0]);
                    r_out_second <= '0;
                    r_out_ovf    <= n_ovf1;
                end
                MODE_DBL: begin
                    r_out_count  <= CNT_ONE;
                    r_out_first  <= signed'(n_res1[W-1:0]);
                    r_out_second <= signed'(n_res1[W-1:0]);
                    r_out_ovf    <= n_ovf1;
                end
                MODE_TWO: begin
                    r_out_count  <= CNT_TWO;
                    r_out_first  <= signed'(n_res1[W-1:0]);
                    r_out_second <= signed'(n_res2[W-1:0]);
                    r_out_ovf    <= n_ovf1 || n_ovf2;
                end
                default: begin
                    r_out_count  <= CNT_NONE;
                    r_out_first  <= '0;
                    r_out_second <= '0;
                    r_out_ovf    <= 1'b0;
                end
            endcase
        end
    end

    // result item port
    assign o_out.valid       = r_out_valid;
    assign o_out.root_count  = r_out_count;
    assign o_out.root_first  = r_out_first;
    assign o_out.root_second = r_out_second;
    assign o_out.overflow    = r_out_ovf;

endmodule

FILE: design/qrs_checker.sv
// port-level checks of the quadratic root solver core and their binding
module qrs_checker #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [1:0]   i_root_count,
    input logic [W-1:0] i_root_first,
    input logic [W-1:0] i_root_second,
    input logic         i_overflow
);
    import qrs_pkg::*;

    // a held result item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_root_first)
            && $stable(i_root_second) && $stable(i_root_count) && $stable(i_overflow))
        else $error("result item changed while stalled");

    // input side stalls only while a result item waits
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // no roots, or every x a root, means zero roots and no overflow
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_root_count == CNT_NONE || i_root_count == CNT_ANY) |->
            i_root_first == '0 && i_root_second == '0 && !i_overflow)
        else $error("roots or overflow set without a root");

    // nothing leaves in the first cycle out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid)
        else $error("result item right after reset");

endmodule

bind quadratic_root_solver_core qrs_checker #(.W(COEF_WIDTH)) u_qrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_root_count (o_out.root_count),
    .i_root_first (o_out.root_first),
    .i_root_second(o_out.root_second),
    .i_overflow   (o_out.overflow)
);

FILE: sim/quadratic_root_solver_core_tb.sv
// self-checking testbench for the quadratic root solver core with its own root predictor
module quadratic_root_solver_core_tb;
    import qrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W          = 32;
    localparam int LIMIT_CYC  = 600000;
    localparam int DRAIN_CYC  = 120;
    localparam int HOLD_CYC   = 300;
    localparam int N_DIR      = 16;
    localparam int N_RAND     = 75;
    localparam logic signed [W-1:0] QMAX = 32'sh7fffffff;
    localparam logic signed [W-1:0] QMIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]          cnt;
        logic signed [W-1:0] r1;
        logic signed [W-1:0] r2;
        logic                ovf;
    } t_roots;

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic                typed;
        t_roots              want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qrs_in_if  #(.W(W)) in_if ();
    qrs_out_if #(.W(W)) out_if ();
    qrs_cfg_if          cfg_if ();

    quadratic_root_solver_core #(.COEF_WIDTH(W), .FRAC_BITS(16)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // clock
    always #2 i_clk = ~i_clk;

    logic [EPS_WIDTH-1:0] eps_shadow = THRESH_RESET;
    t_roots roots_pending [$];
    bit     cur_typed = 1'b0;
    t_roots cur_want;
    int     n_sent = 0, n_checked = 0, n_bad = 0, n_ovf = 0;
    int     cyc = 0;
    bit     calm = 1'b0;
    int     n_cfg = 0;

    // directed coefficient sets, expectations only where obvious
    t_row dir_rows [0:N_DIR-1] = '{
        '{32'sh0, 32'sh0, 32'sh0, 1'b1, '{CNT_ANY, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh0, 32'sh0, 32'sh10000, 1'b1, '{CNT_NONE, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh10000, 32'sh0, 32'sh10000, 1'b1, '{CNT_NONE, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh0, 32'sh10000, -32'sh20000, 1'b1, '{CNT_ONE, 32'sh20000, 32'sh0, 1'b0}},
        '{32'sh10000, -32'sh20000, 32'sh10000, 1'b1,
          '{CNT_ONE, 32'sh10000, 32'sh10000, 1'b0}},
        '{32'sh10000, 32'sh0, -32'sh40000, 1'b1,
          '{CNT_TWO, 32'sh20000, -32'sh20000, 1'b0}},
        '{32'sh1, 32'sh1, 32'sh1, 1'b1, '{CNT_ANY, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh41, 32'sh41, 32'sh42, 1'b1, '{CNT_NONE, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh42, 32'sh0, 32'sh0, 1'b1, '{CNT_ONE, 32'sh0, 32'sh0, 1'b0}},
        '{32'sh0, 32'sh42, QMAX, 1'b1, '{CNT_ONE, QMIN, 32'sh0, 1'b1}},
        '{32'sh0, QMIN, QMAX, 1'b0, '0},
        '{QMAX, QMAX, QMAX, 1'b0, '0},
        '{QMIN, QMIN, QMIN, 1'b0, '0},
        '{QMIN, QMAX, 32'sh0, 1'b0, '0},
        '{QMAX, QMIN, QMIN, 1'b0, '0},
        '{32'sh8000, 32'sh10000, -32'sh8000, 1'b0, '0}
    };

    // saturating fixed-point quotient num/den
    function automatic logic signed [W-1:0] sat_quot(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic ovf);
        logic [127:0] mn, md, q, lim;
        logic neg;
        if (den == 0) begin
            ovf = 1'b1;
            return (num < 0) ? QMIN : QMAX;
        end
        neg = (num < 0) != (den < 0);
        mn  = (num < 0) ? -num : num;
        md  = (den < 0) ? -den : den;
        q   = (mn << 16) / md;
        lim = neg ? 128'h80000000 : 128'h7fffffff;
        if (q > lim) begin
            ovf = 1'b1;
            q = lim;
        end
        return neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    // floor of integer square root
    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] res, bt;
        res = '0;
        bt  = 128'h1 << 126;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // roots of a*x^2+b*x+c under the current threshold
    function automatic t_roots solve_roots(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b,
                                           input logic signed [W-1:0] c,
                                           input logic [EPS_WIDTH-1:0] eps);
        logic signed [127:0] sa, sb, sc, disc, e, s;
        logic [127:0] ma, mb, mc, dmag;
        logic ovf;
        t_roots r;
        sa = a; sb = b; sc = c; e = eps;
        ma = (sa < 0) ? -sa : sa;
        mb = (sb < 0) ? -sb : sb;
        mc = (sc < 0) ? -sc : sc;
        ovf = 1'b0;
        r = '{CNT_NONE, 32'sh0, 32'sh0, 1'b0};
        if (ma < e) begin
            if (mb < e) begin
                r.cnt = (mc < e) ? CNT_ANY : CNT_NONE;
            end else begin
                r.r1  = sat_quot(-sc, sb, ovf);
                r.cnt = CNT_ONE;
            end
        end else begin
            disc = sb * sb - 4 * sa * sc;
            dmag = (disc < 0) ? -disc : disc;
            if (dmag < (e << 16)) begin
                r.r1  = sat_quot(-sb, 2 * sa, ovf);
                r.r2  = r.r1;
                r.cnt = CNT_ONE;
            end else if (disc >= 0) begin
                s     = floor_sqrt(dmag);
                r.r1  = sat_quot(-sb + s, 2 * sa, ovf);
                r.r2  = sat_quot(-sb - s, 2 * sa, ovf);
                r.cnt = CNT_TWO;
            end
        end
        r.ovf = ovf;
        return r;
    endfunction

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cyc, roots_pending.size());
            $display("quadratic_root_solver_core_tb: errors");
            $finish;
        end
    end

    // accepted items: threshold writes, coefficient items, result items
    always @(posedge i_clk) begin
        t_roots got, want;
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            eps_shadow = cfg_if.data;
            n_cfg++;
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            roots_pending.push_back(cur_typed ? cur_want :
                solve_roots(in_if.coef_a, in_if.coef_b, in_if.coef_c, eps_shadow));
            n_sent++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.root_count, out_if.root_first, out_if.root_second,
                    out_if.overflow};
            if (roots_pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result item cnt=%0d x1=%h x2=%h ovf=%b",
                             got.cnt, got.r1, got.r2, got.ovf);
            end else begin
                want = roots_pending.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("item %0d: want cnt=%0d x1=%h x2=%h ovf=%b, got cnt=%0d x1=%h x2=%h ovf=%b",
                                 n_checked, want.cnt, want.r1, want.r2, want.ovf,
                                 got.cnt, got.r1, got.r2, got.ovf);
                end
                if (got.ovf) n_ovf++;
                n_checked++;
            end
        end
    end

    // receiver: random stalls, one long hold-off once the pipe is busy, a calm stretch
    initial begin
        int held;
        held = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (held == 0 && n_sent >= 60) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                held = 1;
            end
            out_if.ready = calm ? 1'b1 : ($urandom_range(99) >= 18);
        end
    end

    // write the threshold register
    task automatic write_eps(input logic [EPS_WIDTH-1:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // offer one coefficient item, with random gaps in front
    task automatic offer_coefs(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                               input logic signed [W-1:0] c, input bit typed,
                               input t_roots want);
        while (!calm && $urandom_range(99) < 18) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid  = 1'b1;
        in_if.coef_a = a;
        in_if.coef_b = b;
        in_if.coef_c = c;
        cur_typed    = typed;
        cur_want     = want;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // value just around the threshold, either sign
    function automatic logic signed [W-1:0] near_eps();
        logic signed [W-1:0] v;
        v = $signed({16'h0, eps_shadow}) + $urandom_range(2) - 1;
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return QMAX;
            1: return QMIN;
            2: return 32'sh0;
            default: return -32'sh1;
        endcase
    endfunction

    // random coefficient item, half of them equations built from known roots
    task automatic offer_random();
        logic signed [W-1:0] a, b, c;
        int k, p, q;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                k = $urandom_range(8) + 1;
                if ($urandom_range(1)) k = -k;
                p = $urandom_range(100) - 50;
                q = $urandom_range(100) - 50;
                a = k <<< 16;
                b = (-k * (p + q)) <<< 16;
                c = (k * p * q) <<< 16;
                if ($urandom_range(3) == 0) c = c + $urandom_range(255) - 128;
            end
            5: begin
                a = $urandom_range(1 << 20) - (1 << 19);
                b = $urandom_range(1 << 20) - (1 << 19);
                c = $urandom_range(1 << 20) - (1 << 19);
            end
            6: begin
                a = $urandom;
                b = $urandom;
                c = $urandom;
            end
            7: begin
                a = $urandom_range(1) ? near_eps() : 32'sh0;
                b = $urandom_range(1) ? near_eps() : $urandom;
                c = $urandom_range(1) ? near_eps() : $urandom;
            end
            8: begin
                a = pick_extreme();
                b = $urandom_range(1) ? pick_extreme() : $urandom;
                c = $urandom_range(1) ? pick_extreme() : $urandom;
            end
            default: begin
                a = $urandom_range(1) ? 32'sh0 : near_eps();
                b = $urandom_range(1) ? $urandom : $urandom_range(1 << 18);
                c = $urandom;
            end
        endcase
        offer_coefs(a, b, c, 1'b0, '0);
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (roots_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [EPS_WIDTH-1:0] eps_plan [0:5];
        eps_plan = '{THRESH_RESET, 16'd0, 16'hffff, 16'd1, 16'd0, THRESH_RESET};
        eps_plan[4] = $urandom_range(16'hffff);
        in_if.valid  = 1'b0;
        in_if.coef_a = '0;
        in_if.coef_b = '0;
        in_if.coef_c = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_eps(eps_plan[ph]);
            if (ph == 0) begin
                foreach (dir_rows[i])
                    offer_coefs(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                                dir_rows[i].typed, dir_rows[i].want);
                @(negedge i_clk);
                cur_typed = 1'b0;
            end
            for (int n = 0; n < N_RAND; n++) begin
                calm = (ph == 2 && n >= 20 && n < 60);
                offer_random();
            end
            calm = 1'b0;
            drain();
        end

        $display("ran %0d coefficient items over %0d threshold settings, %0d results checked",
                 n_sent, n_cfg + 1, n_checked);
        $display("%0d results saturated, %0d mismatches", n_ovf, n_bad);
        if (n_bad == 0)
            $display("quadratic_root_solver_core_tb: clean");
        else
            $display("quadratic_root_solver_core_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/qrs_pkg.sv
design/qrs_if.sv
design/quadratic_root_solver_core.sv
design/qrs_checker.sv
sim/quadratic_root_solver_core_tb.sv
